@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the core RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AON_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define AON_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define AON_ASSERT_RST(label, clk, rst_n, prop)
`define AON_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/core/aon_pkg.sv @@
// Types, widths and helpers of the axes orthonormalizer.
package aon_pkg;

    localparam int COMP_W       = 32;
    localparam int WIDE_W       = 36;
    localparam int MAG_W        = 31;
    localparam int TOP_POS      = MAG_W - 1;
    localparam int POS_W        = 6;
    localparam int SUM_W        = 64;
    localparam int ROOT_W       = 32;
    localparam int NUM_W        = 62;
    localparam int QUO_W        = 31;
    localparam int PROD_W       = 64;
    localparam int DQ_W         = 34;
    localparam int FRAC_SHIFT   = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int SQ_BASE      = 4;
    localparam int DV_BASE      = SQ_BASE + SQRT_STEPS + 1;
    localparam int OUT_STAGE    = DV_BASE + DIV_STEPS + 1;
    localparam int NORM_STAGES  = OUT_STAGE + 1;
    localparam int PROJ_STAGES  = 5;

    localparam logic signed [COMP_W-1:0] ONE = COMP_W'(1) << FRAC_SHIFT;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        t_comp [2:0] a;
        t_comp [2:0] b;
        t_comp [2:0] c;
        t_comp [2:0] u1;
        t_comp [2:0] u2;
        logic        ok;
    } t_side;

    typedef struct packed {
        t_comp first_axis_x;
        t_comp first_axis_y;
        t_comp first_axis_z;
        t_comp second_axis_x;
        t_comp second_axis_y;
        t_comp second_axis_z;
        t_comp third_axis_x;
        t_comp third_axis_y;
        t_comp third_axis_z;
    } t_in_item;

    typedef struct packed {
        t_comp unit_first_x;
        t_comp unit_first_y;
        t_comp unit_first_z;
        t_comp unit_second_x;
        t_comp unit_second_y;
        t_comp unit_second_z;
        t_comp unit_third_x;
        t_comp unit_third_y;
        t_comp unit_third_z;
        logic  fell_back;
    } t_out_item;

    // round to nearest, halves away from zero, by 2^FRAC_SHIFT
    function automatic logic signed [PROD_W-1:0] rnd_frac(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + (PROD_W'(1) << (FRAC_SHIFT - 1)) - {{(PROD_W-1){1'b0}}, x[PROD_W-1]};
        return t >>> FRAC_SHIFT;
    endfunction

endpackage

@@ rtl/core/aon_in_if.sv @@
// Input channel: one set of three axis vectors per transaction.
interface aon_in_if;
    logic              valid;
    logic              ready;
    aon_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/aon_out_if.sv @@
// Output channel: one orthonormal axis set per transaction.
interface aon_out_if;
    logic               valid;
    logic               ready;
    aon_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/aon_norm.sv @@
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
`include "assert_macros.svh"
module aon_norm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  aon_pkg::t_wide [2:0]  i_vec,
    input  aon_pkg::t_side        i_side,
    output logic                  o_valid,
    output aon_pkg::t_comp [2:0]  o_unit,
    output logic                  o_nz,
    output aon_pkg::t_side        o_side
);
    import aon_pkg::*;

    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        logic [SUM_W-1:0] n;
        logic [SUM_W-1:0] r;
        t_mag [2:0]       mg;
    } t_sq_st;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][QUO_W-1:0] q;
        logic [ROOT_W-1:0]     m;
    } t_dv_st;

    logic                   r_vld  [NORM_STAGES];
    logic                   r_nz   [NORM_STAGES];
    logic [2:0]             r_sign [NORM_STAGES];
    t_side                  r_side [NORM_STAGES];

    logic [2:0][WIDE_W-1:0] r_mag_a, n_mag_a, r_mag_b;
    logic [WIDE_W-1:0]      r_top_a, n_top_a;
    logic [POS_W-1:0]       r_pos_b, n_pos_b;
    t_mag [2:0]             r_mag_c, n_mag_c, r_mag_d;
    logic [2:0][2*MAG_W-1:0] r_sq_d, n_sq_d;
    t_sq_st                 r_sq [SQRT_STEPS+1];
    t_sq_st                 n_sq [SQRT_STEPS+1];
    t_dv_st                 r_dv [DIV_STEPS+1];
    t_dv_st                 n_dv [DIV_STEPS+1];
    t_comp [2:0]            r_unit, n_unit;
    logic                   w_rem_ok, w_quot_ok;

    // magnitudes and largest one
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag_a[i] = i_vec[i][WIDE_W-1] ? WIDE_W'(-$signed(i_vec[i])) : i_vec[i];
        end
        n_top_a = n_mag_a[0];
        if (n_mag_a[1] > n_top_a) begin
            n_top_a = n_mag_a[1];
        end
        if (n_mag_a[2] > n_top_a) begin
            n_top_a = n_mag_a[2];
        end
    end

    // leading one of the largest magnitude
    always_comb begin
        n_pos_b = '0;
        for (int b = 0; b < WIDE_W; b++) begin
            if (r_top_a[b]) begin
                n_pos_b = POS_W'(b);
            end
        end
    end

    // common scaling so the largest lies in [2^30, 2^31)
    always_comb begin
        logic [WIDE_W-1:0] sh;
        sh = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_pos_b >= POS_W'(TOP_POS)) begin
                sh = r_mag_b[i] >> (r_pos_b - POS_W'(TOP_POS));
            end else begin
                sh = r_mag_b[i] << (POS_W'(TOP_POS) - r_pos_b);
            end
            n_mag_c[i] = sh[MAG_W-1:0];
            n_sq_d[i]  = (2*MAG_W)'(r_mag_c[i]) * (2*MAG_W)'(r_mag_c[i]);
        end
    end

    // square root, one result bit per stage
    always_comb begin
        logic [SUM_W-1:0] step_bit;
        logic [SUM_W-1:0] trial;
        n_sq[0].n  = SUM_W'(r_sq_d[0]) + SUM_W'(r_sq_d[1]) + SUM_W'(r_sq_d[2]);
        n_sq[0].r  = '0;
        n_sq[0].mg = r_mag_d;
        for (int k = 1; k <= SQRT_STEPS; k++) begin
            step_bit = SUM_W'(1) << (2 * (SQRT_STEPS - k));
            trial    = r_sq[k-1].r + step_bit;
            n_sq[k]  = r_sq[k-1];
            if (r_sq[k-1].n >= trial) begin
                n_sq[k].n = r_sq[k-1].n - trial;
                n_sq[k].r = (r_sq[k-1].r >> 1) + step_bit;
            end else begin
                n_sq[k].r = r_sq[k-1].r >> 1;
            end
        end
    end

    // rounded restoring division, one quotient bit per stage
    always_comb begin
        logic [NUM_W-1:0] dvs;
        logic             hit;
        n_dv[0].m = r_sq[SQRT_STEPS].r[ROOT_W-1:0];
        n_dv[0].q = '0;
        for (int i = 0; i < 3; i++) begin
            n_dv[0].rem[i] = NUM_W'({r_sq[SQRT_STEPS].mg[i], {FRAC_SHIFT{1'b0}}})
                           + NUM_W'(r_sq[SQRT_STEPS].r[ROOT_W-1:1]);
        end
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_dv[k] = r_dv[k-1];
            dvs     = NUM_W'(r_dv[k-1].m) << (DIV_STEPS - k);
            for (int i = 0; i < 3; i++) begin
                hit = r_dv[k-1].rem[i] >= dvs;
                if (hit) begin
                    n_dv[k].rem[i] = r_dv[k-1].rem[i] - dvs;
                end
                n_dv[k].q[i] = {r_dv[k-1].q[i][QUO_W-2:0], hit};
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_unit[i] = r_sign[OUT_STAGE-1][i] ? -$signed(COMP_W'(r_dv[DIV_STEPS].q[i]))
                                               : $signed(COMP_W'(r_dv[DIV_STEPS].q[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NORM_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NORM_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_nz[0]   <= |i_vec;
            r_sign[0] <= {i_vec[2][WIDE_W-1], i_vec[1][WIDE_W-1], i_vec[0][WIDE_W-1]};
            for (int k = 1; k < NORM_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
                r_nz[k]   <= r_nz[k-1];
                r_sign[k] <= r_sign[k-1];
            end
            r_mag_a <= n_mag_a;
            r_top_a <= n_top_a;
            r_mag_b <= r_mag_a;
            r_pos_b <= n_pos_b;
            r_mag_c <= n_mag_c;
            r_sq_d  <= n_sq_d;
            r_mag_d <= r_mag_c;
            for (int k = 0; k <= SQRT_STEPS; k++) begin
                r_sq[k] <= n_sq[k];
            end
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_unit <= n_unit;
        end
    end

    assign o_valid = r_vld[OUT_STAGE];
    assign o_nz    = r_nz[OUT_STAGE];
    assign o_side  = r_side[OUT_STAGE];
    assign o_unit  = r_unit;

    assign w_rem_ok  = r_sq[SQRT_STEPS].n <= (r_sq[SQRT_STEPS].r << 1);
    assign w_quot_ok = (r_dv[DIV_STEPS].q[0] <= QUO_W'(ONE))
                    && (r_dv[DIV_STEPS].q[1] <= QUO_W'(ONE))
                    && (r_dv[DIV_STEPS].q[2] <= QUO_W'(ONE));

    // square root remainder never exceeds twice the root
    `AON_ASSERT_RST(a_root_rem, i_clk, i_rst_n, r_vld[DV_BASE-1] |-> w_rem_ok)
    // unit components stay within one
    `AON_ASSERT_RST(a_quot_max, i_clk, i_rst_n, r_vld[OUT_STAGE-1] && r_nz[OUT_STAGE-1] |-> w_quot_ok)
    // a nonzero vector never divides by a zero root
    `AON_ASSERT_RST(a_root_nz, i_clk, i_rst_n, r_vld[OUT_STAGE-1] && r_nz[OUT_STAGE-1] |-> (|r_dv[DIV_STEPS].m))

endmodule

@@ rtl/core/axes_orthonormalizer_core.sv @@
// Top level of the axes orthonormalizer pipeline.
//
// Usage:
//   i_axes carries three axis vectors, signed Q4.27 components, one set per
//   transaction (valid and ready both high at a rising edge).
//   o_units returns the orthonormal axes in signed Q1.30 plus fell_back.
//   The first axis keeps its direction, the second and third lose their
//   projections on the earlier axes, and all three are scaled to unit length.
//   If a vector to be normalized is zero, identity axes come out with
//   fell_back set.
// Throughput: one transaction per cycle while the output is not stalled.
// Pipeline: between input acceptance and output valid lie three
//   normalizers (70 stages each: 32-stage square root, 31-stage divider)
//   and two 5-stage projection removers, plus the output register.
// Reset (i_rst_n low, synchronous) clears all valid bits and holds
//   i_axes.ready low; nothing in flight survives it.
// Stall: when o_units.ready is low with a result held, the whole pipeline
//   freezes and i_axes.ready drops; nothing is lost or repeated.
`include "assert_macros.svh"
module axes_orthonormalizer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aon_in_if.sink    i_axes,
    aon_out_if.source o_units
);
    import aon_pkg::*;

    logic                   w_en;
    t_wide [2:0]            w_v1;
    t_side                  w_s1;

    logic                   n1_vld, n2_vld, n3_vld;
    t_comp [2:0]            n1_unit, n2_unit, n3_unit;
    logic                   n1_nz, n2_nz, n3_nz;
    t_side                  n1_side, n2_side, n3_side;

    logic                   w_pin_vld  [2];
    t_side                  w_pin_side [2];

    logic                   r_pvld  [2][PROJ_STAGES];
    t_side                  r_pside [2][PROJ_STAGES];
    logic [2:0][PROD_W-1:0] r_pa [2], r_pb [2], n_pa [2], n_pb [2];
    logic [PROD_W-1:0]      r_sa [2], r_sb [2], n_sa [2], n_sb [2];
    logic [DQ_W-1:0]        r_dqa [2], r_dqb [2], n_dqa [2], n_dqb [2];
    logic [2:0][PROD_W-1:0] r_ra [2], r_rb [2], n_ra [2], n_rb [2];
    t_wide [2:0]            r_pvec [2], n_pvec [2];

    logic                   r_out_vld;
    t_out_item              r_out, n_out;
    logic                   w_second_ok, w_third_ok;

    assign w_en          = !r_out_vld || o_units.ready;
    assign i_axes.ready  = w_en && i_rst_n;
    assign o_units.valid = r_out_vld;
    assign o_units.payload = r_out;

    always_comb begin
        w_v1[0] = WIDE_W'(i_axes.payload.first_axis_x);
        w_v1[1] = WIDE_W'(i_axes.payload.first_axis_y);
        w_v1[2] = WIDE_W'(i_axes.payload.first_axis_z);
        w_s1.a  = {i_axes.payload.first_axis_z, i_axes.payload.first_axis_y,
                   i_axes.payload.first_axis_x};
        w_s1.b  = {i_axes.payload.second_axis_z, i_axes.payload.second_axis_y,
                   i_axes.payload.second_axis_x};
        w_s1.c  = {i_axes.payload.third_axis_z, i_axes.payload.third_axis_y,
                   i_axes.payload.third_axis_x};
        w_s1.u1 = '0;
        w_s1.u2 = '0;
        w_s1.ok = 1'b0;
    end

    aon_norm u_norm1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_axes.valid),
        .i_vec   (w_v1),
        .i_side  (w_s1),
        .o_valid (n1_vld),
        .o_unit  (n1_unit),
        .o_nz    (n1_nz),
        .o_side  (n1_side)
    );

    // lane 0: second axis against u1; lane 1: third axis against u1 and u2
    always_comb begin
        w_pin_vld[0]     = n1_vld;
        w_pin_side[0]    = n1_side;
        w_pin_side[0].u1 = n1_unit;
        w_pin_side[0].ok = n1_nz;
        w_pin_vld[1]     = n2_vld;
        w_pin_side[1]    = n2_side;
        w_pin_side[1].u2 = n2_unit;
        w_pin_side[1].ok = n2_side.ok && n2_nz;
    end

    always_comb begin
        t_comp [2:0] x1;
        t_comp [2:0] x5;
        for (int j = 0; j < 2; j++) begin
            x1 = (j == 0) ? w_pin_side[j].b : w_pin_side[j].c;
            x5 = (j == 0) ? r_pside[j][3].b : r_pside[j][3].c;
            for (int i = 0; i < 3; i++) begin
                n_pa[j][i] = PROD_W'($signed(w_pin_side[j].u1[i])) * PROD_W'($signed(x1[i]));
                n_pb[j][i] = PROD_W'($signed(w_pin_side[j].u2[i])) * PROD_W'($signed(x1[i]));
                n_ra[j][i] = PROD_W'($signed(r_dqa[j])) * PROD_W'($signed(r_pside[j][2].u1[i]));
                n_rb[j][i] = PROD_W'($signed(r_dqb[j])) * PROD_W'($signed(r_pside[j][2].u2[i]));
                n_pvec[j][i] = WIDE_W'($signed(x5[i]))
                             - WIDE_W'(rnd_frac($signed(r_ra[j][i])))
                             - WIDE_W'(rnd_frac($signed(r_rb[j][i])));
            end
            n_sa[j]  = r_pa[j][0] + r_pa[j][1] + r_pa[j][2];
            n_sb[j]  = r_pb[j][0] + r_pb[j][1] + r_pb[j][2];
            n_dqa[j] = DQ_W'(rnd_frac($signed(r_sa[j])));
            n_dqb[j] = DQ_W'(rnd_frac($signed(r_sb[j])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 2; j++) begin
                for (int k = 0; k < PROJ_STAGES; k++) begin
                    r_pvld[j][k] <= 1'b0;
                end
            end
        end else if (w_en) begin
            for (int j = 0; j < 2; j++) begin
                r_pvld[j][0] <= w_pin_vld[j];
                for (int k = 1; k < PROJ_STAGES; k++) begin
                    r_pvld[j][k] <= r_pvld[j][k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 2; j++) begin
                r_pside[j][0] <= w_pin_side[j];
                for (int k = 1; k < PROJ_STAGES; k++) begin
                    r_pside[j][k] <= r_pside[j][k-1];
                end
                r_pa[j]   <= n_pa[j];
                r_pb[j]   <= n_pb[j];
                r_sa[j]   <= n_sa[j];
                r_sb[j]   <= n_sb[j];
                r_dqa[j]  <= n_dqa[j];
                r_dqb[j]  <= n_dqb[j];
                r_ra[j]   <= n_ra[j];
                r_rb[j]   <= n_rb[j];
                r_pvec[j] <= n_pvec[j];
            end
        end
    end

    aon_norm u_norm2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_pvld[0][PROJ_STAGES-1]),
        .i_vec   (r_pvec[0]),
        .i_side  (r_pside[0][PROJ_STAGES-1]),
        .o_valid (n2_vld),
        .o_unit  (n2_unit),
        .o_nz    (n2_nz),
        .o_side  (n2_side)
    );

    aon_norm u_norm3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_pvld[1][PROJ_STAGES-1]),
        .i_vec   (r_pvec[1]),
        .i_side  (r_pside[1][PROJ_STAGES-1]),
        .o_valid (n3_vld),
        .o_unit  (n3_unit),
        .o_nz    (n3_nz),
        .o_side  (n3_side)
    );

    always_comb begin
        if (n3_side.ok && n3_nz) begin
            n_out.unit_first_x  = n3_side.u1[0];
            n_out.unit_first_y  = n3_side.u1[1];
            n_out.unit_first_z  = n3_side.u1[2];
            n_out.unit_second_x = n3_side.u2[0];
            n_out.unit_second_y = n3_side.u2[1];
            n_out.unit_second_z = n3_side.u2[2];
            n_out.unit_third_x  = n3_unit[0];
            n_out.unit_third_y  = n3_unit[1];
            n_out.unit_third_z  = n3_unit[2];
            n_out.fell_back     = 1'b0;
        end else begin
            n_out.unit_first_x  = ONE;
            n_out.unit_first_y  = '0;
            n_out.unit_first_z  = '0;
            n_out.unit_second_x = '0;
            n_out.unit_second_y = ONE;
            n_out.unit_second_z = '0;
            n_out.unit_third_x  = '0;
            n_out.unit_third_y  = '0;
            n_out.unit_third_z  = ONE;
            n_out.fell_back     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= n3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign w_second_ok = (r_out.unit_second_x <= ONE) && (r_out.unit_second_x >= -ONE)
                      && (r_out.unit_second_y <= ONE) && (r_out.unit_second_y >= -ONE)
                      && (r_out.unit_second_z <= ONE) && (r_out.unit_second_z >= -ONE);
    assign w_third_ok  = (r_out.unit_third_x <= ONE) && (r_out.unit_third_x >= -ONE)
                      && (r_out.unit_third_y <= ONE) && (r_out.unit_third_y >= -ONE)
                      && (r_out.unit_third_z <= ONE) && (r_out.unit_third_z >= -ONE);

    `AON_ASSERT_RST(a_second_range, i_clk, i_rst_n, r_out_vld && !r_out.fell_back |-> w_second_ok)
    `AON_ASSERT_RST(a_third_range, i_clk, i_rst_n, r_out_vld && !r_out.fell_back |-> w_third_ok)
    // a stalled result holds until taken
    `AON_ASSERT_RST(a_out_hold, i_clk, i_rst_n, r_out_vld && !o_units.ready |=> r_out_vld && $stable(r_out))

endmodule
